[rtl/core/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
// Used by the front end, the command queue, the back end and the top level.
`default_nettype none

package ffba_pkg;

   localparam int BLOCK_COUNT   = 1024;
   localparam int BLOCK_BYTES   = 24;
   localparam int PAYLOAD_BYTES = 16;
   localparam int HEADER_BYTES  = 8;
   localparam int MAX_REQUEST   = 16384;
   localparam logic [31:0] RESET_BASE = 32'h0001_0000;

   localparam int ADDR_W    = 32;
   localparam int BYTES_W   = 15;
   localparam int IDX_W     = $clog2(BLOCK_COUNT);
   localparam int LEN_W     = $clog2(BLOCK_COUNT + 1);
   localparam int PAY_SHIFT = $clog2(PAYLOAD_BYTES);
   localparam int NEED_W    = BYTES_W + 1 - PAY_SHIFT;

   // Free address decode: offset range and reciprocal for division by BLOCK_BYTES
   localparam int HEAP_SPAN   = BLOCK_COUNT * BLOCK_BYTES;
   localparam int OFF_W       = $clog2(HEAP_SPAN);
   localparam int RECIP_SHIFT = $clog2(HEAP_SPAN * BLOCK_BYTES);
   localparam int RECIP       = ((1 << RECIP_SHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;
   localparam int RECIP_W     = RECIP_SHIFT - $clog2(BLOCK_BYTES) + 2;
   localparam int PROD_W      = OFF_W + RECIP_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      ST_DONE        = 2'd0,
      ST_NO_SPACE    = 2'd1,
      ST_NOT_USED    = 2'd2,
      ST_BAD_ADDRESS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_NO_SPACE = 2'd1,
      OP_FREE     = 2'd2,
      OP_BAD_ADDR = 2'd3
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [LEN_W-1:0] need;
      logic [IDX_W-1:0] index;
   } cmd_type;

   typedef struct packed {
      logic             used;
      logic [LEN_W-1:0] len;
   } hdr_type;

   typedef struct packed {
      status_type        status;
      logic [LEN_W-1:0]  granted;
      logic [IDX_W-1:0]  first;
      logic [ADDR_W-1:0] addr;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/first_fit_block_allocator.sv]
// First-fit allocator over a heap of fixed blocks, top level.
// Depends on ffba_pkg, ffba_front, ffba_queue and ffba_back.
//
// After reset the block clears every header of its header memory and holds
// req_tready low meanwhile; csr writes are taken at any time. The allocate walk
// visits run headers in order and reads one header per cycle from the single
// header memory. The front end captures a request, then sizes it or decodes its
// address, then pushes the command, stalling while the queue is full; it takes
// no new request until that push is done. A four-entry queue lets it take new
// requests while the back end walks or a result waits on rsp_tready.
`default_nettype none

module first_fit_block_allocator
   import ffba_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // request_bytes[14:0], release_address[46:15]
   input  wire logic                  req_tuser,  // kind: 0 allocate, 1 free
   // response
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // payload_address[31:0], first_block[41:32],
                                                  // blocks_granted[52:42], status[54:53]
   // heap base register
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [ADDR_W-1:0]     csr_data
);

   logic [ADDR_W-1:0] heap_base_ff;
   logic              clearing;
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type           cmd_in_data, cmd_out_data;
   rsp_type           rsp_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= RESET_BASE;
      end else if (csr_valid) begin
         heap_base_ff <= csr_data;
      end
   end

   ffba_front u_front (
      .clock       (clock),
      .reset       (reset),
      .hold        (clearing),
      .heap_base   (heap_base_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_bytes   (req_tdata[BYTES_W-1:0]),
      .req_address (req_tdata[BYTES_W +: ADDR_W]),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in_data),
      .cmd_full    (cmd_full)
   );

   ffba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   ffba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .heap_base (heap_base_ff),
      .clearing  (clearing),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {1'b0, rsp_data.status, rsp_data.granted, rsp_data.first, rsp_data.addr};

endmodule

`default_nettype wire

[rtl/core/ffba_queue.sv]
// Short command queue between the allocator front end and back end.
// Depends on ffba_pkg for the command type and depth.
`default_nettype none

module ffba_queue
   import ffba_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ffba_front.sv]
// Allocator front end: takes request transactions, sizes allocations and
// decodes free addresses into block indexes. Depends on ffba_pkg.
`default_nettype none

module ffba_front
   import ffba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               hold,
   input  wire logic [ADDR_W-1:0]  heap_base,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [BYTES_W-1:0] req_bytes,
   input  wire logic [ADDR_W-1:0]  req_address,
   output logic                    cmd_push,
   output cmd_type                 cmd_data,
   input  wire logic               cmd_full
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CALC,
      F_PUSH
   } fstate_type;

   fstate_type           state_ff, state_in;
   logic                 kind_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic                 in_range_ff, in_range_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [IDX_W-1:0]     quot_ff, quot_in;

   logic [ADDR_W-1:0]    off_full;
   logic [PROD_W-1:0]    product;
   logic [BYTES_W:0]     need_sum;
   logic [NEED_W-1:0]    need_raw;
   logic [OFF_W-1:0]     back_mul;
   logic                 accept;

   assign req_ready = (state_ff == F_IDLE) && !hold;
   assign accept    = req_valid && req_ready;

   always_comb begin
      off_full    = addr_ff - heap_base - ADDR_W'(HEADER_BYTES);
      in_range_in = (off_full < ADDR_W'(HEAP_SPAN));
      off_in      = off_full[OFF_W-1:0];
      product     = PROD_W'(off_in) * PROD_W'(RECIP);
      quot_in     = product[RECIP_SHIFT +: IDX_W];

      need_sum = {1'b0, bytes_ff} + (BYTES_W+1)'(PAYLOAD_BYTES - 1);
      need_raw = NEED_W'(need_sum >> PAY_SHIFT);
      back_mul = OFF_W'(32'(quot_ff) * 32'(BLOCK_BYTES));

      cmd_data       = '0;
      cmd_data.index = quot_ff;
      if (!kind_ff) begin
         if (bytes_ff > BYTES_W'(MAX_REQUEST) || need_raw > NEED_W'(BLOCK_COUNT)) begin
            cmd_data.op = OP_NO_SPACE;
         end else begin
            cmd_data.op = OP_ALLOC;
         end
         // a zero-byte request still takes one block
         cmd_data.need = (need_raw == '0) ? LEN_W'(1) : LEN_W'(need_raw);
      end else if (in_range_ff && back_mul == off_ff) begin
         cmd_data.op = OP_FREE;
      end else begin
         cmd_data.op = OP_BAD_ADDR;
      end

      cmd_push = (state_ff == F_PUSH) && !cmd_full;

      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_CALC;
         end
         F_CALC: begin
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!cmd_full) state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         kind_ff  <= req_kind;
         bytes_ff <= req_bytes;
         addr_ff  <= req_address;
      end
      if (state_ff == F_CALC) begin
         in_range_ff <= in_range_in;
         off_ff      <= off_in;
         quot_ff     <= quot_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ffba_back.sv]
// Allocator back end: header memory, clearing pass, first-fit walk, free
// and the result register. Depends on ffba_pkg.
`default_nettype none

module ffba_back
   import ffba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [ADDR_W-1:0] heap_base,
   output logic                   clearing,
   input  wire logic              cmd_empty,
   input  wire cmd_type           cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data
);

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_WALK,
      B_SPLIT,
      B_FREE
   } bstate_type;

   hdr_type              hdr_mem [BLOCK_COUNT];
   hdr_type              rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   hdr_type              wr_data;

   bstate_type           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]     need_ff, need_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [IDX_W-1:0]     split_idx_ff, split_idx_in;
   logic [LEN_W-1:0]     split_len_ff, split_len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [LEN_W-1:0]     room;
   logic [LEN_W-1:0]     step;
   logic [LEN_W-1:0]     next_idx;
   logic [LEN_W-1:0]     split_at;
   logic [ADDR_W-1:0]    grant_addr;
   logic                 emit;
   rsp_type              emit_data;

   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      room       = LEN_W'(BLOCK_COUNT) - {1'b0, idx_ff};
      step       = (rd_data_ff.len == '0) ? LEN_W'(1) : rd_data_ff.len;
      next_idx   = {1'b0, idx_ff} + step;
      split_at   = {1'b0, idx_ff} + need_ff;
      grant_addr = heap_base + 32'(BLOCK_BYTES) * 32'(idx_ff) + ADDR_W'(HEADER_BYTES);

      state_in     = state_ff;
      idx_in       = idx_ff;
      need_in      = need_ff;
      clr_in       = clr_ff;
      split_idx_in = split_idx_ff;
      split_len_in = split_len_ff;
      cmd_pop      = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;
      emit         = 1'b0;
      emit_data    = '0;
      emit_data.status = ST_NO_SPACE;

      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(BLOCK_COUNT - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            // start only with the result register free
            if (!cmd_empty && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  OP_ALLOC: begin
                     rd_addr  = '0;
                     idx_in   = '0;
                     need_in  = cmd_data.need;
                     state_in = B_WALK;
                  end
                  OP_FREE: begin
                     rd_addr  = cmd_data.index;
                     idx_in   = cmd_data.index;
                     state_in = B_FREE;
                  end
                  OP_NO_SPACE: begin
                     emit             = 1'b1;
                     emit_data.status = ST_NO_SPACE;
                  end
                  default: begin
                     emit             = 1'b1;
                     emit_data.status = ST_BAD_ADDRESS;
                  end
               endcase
            end
         end
         B_WALK: begin
            if (!rd_data_ff.used && rd_data_ff.len == '0 && need_ff > room) begin
               // untouched frontier without room up to the heap end
               emit     = 1'b1;
               state_in = B_IDLE;
            end else if (!rd_data_ff.used &&
                         (rd_data_ff.len == '0 || rd_data_ff.len >= need_ff)) begin
               wr_en             = 1'b1;
               wr_data.used      = 1'b1;
               wr_data.len       = need_ff;
               emit              = 1'b1;
               emit_data.addr    = grant_addr;
               emit_data.first   = idx_ff;
               emit_data.granted = need_ff;
               emit_data.status  = ST_DONE;
               state_in          = B_IDLE;
               // split off the remainder of a longer reused run
               if (rd_data_ff.len > need_ff && split_at < LEN_W'(BLOCK_COUNT)) begin
                  split_idx_in = split_at[IDX_W-1:0];
                  split_len_in = rd_data_ff.len - need_ff;
                  state_in     = B_SPLIT;
               end
            end else if (step >= room) begin
               emit     = 1'b1;
               state_in = B_IDLE;
            end else begin
               rd_addr = next_idx[IDX_W-1:0];
               idx_in  = next_idx[IDX_W-1:0];
            end
         end
         B_SPLIT: begin
            wr_en        = 1'b1;
            wr_addr      = split_idx_ff;
            wr_data.used = 1'b0;
            wr_data.len  = split_len_ff;
            state_in     = B_IDLE;
         end
         B_FREE: begin
            emit            = 1'b1;
            emit_data.first = idx_ff;
            state_in        = B_IDLE;
            if (!rd_data_ff.used) begin
               emit_data.status = ST_NOT_USED;
            end else begin
               wr_en            = 1'b1;
               wr_data.used     = 1'b0;
               wr_data.len      = rd_data_ff.len;
               emit_data.status = ST_DONE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      need_ff      <= need_in;
      split_idx_ff <= split_idx_in;
      split_len_ff <= split_len_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hdr_mem[rd_addr];
   end

endmodule

`default_nettype wire
